@@ rtl/job_dispatcher_idle_stack_backlog_assert.svh @@
// Assertion macros shared by the dispatcher modules.
// Each macro expects clk and rst in the scope where it is used.
`ifndef JOB_DISPATCHER_IDLE_STACK_BACKLOG_ASSERT_SVH
`define JOB_DISPATCHER_IDLE_STACK_BACKLOG_ASSERT_SVH

// same-cycle implication
`define JDISB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define JDISB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/jdisb_pkg.sv @@
// Package for the job dispatcher: sizes, event and action codes, command struct.
// No dependencies.
package jdisb_pkg;

  localparam int MAX_WORKERS   = 8;
  localparam int BACKLOG_DEPTH = 64;
  localparam int JOB_TAG_BITS  = 16;
  localparam int COUNT_RESET   = 8;

  localparam int CFG_W  = 4;
  localparam int WID_W  = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int CNT_W  = $clog2(MAX_WORKERS + 1);
  localparam int PTR_W  = (BACKLOG_DEPTH > 1) ? $clog2(BACKLOG_DEPTH) : 1;
  localparam int FILL_W = $clog2(BACKLOG_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_POST     = 2'd0,
    KIND_FINISH   = 2'd1,
    KIND_SHUTDOWN = 2'd2,
    KIND_BAD      = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ACT_STARTED   = 3'd0,
    ACT_QUEUED    = 3'd1,
    ACT_DROP_FULL = 3'd2,
    ACT_DROP_SHUT = 3'd3,
    ACT_IDLE      = 3'd4,
    ACT_SHUT_DONE = 3'd5,
    ACT_ERROR     = 3'd6
  } action_t;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } dp_cmd_t;

endpackage

@@ rtl/jdisb_if.sv @@
// Channel interfaces of the dispatcher: event input, result output, configuration.
// Depends on jdisb_pkg.
interface jdisb_evt_if;
  logic                              valid;
  logic                              ready;
  jdisb_pkg::kind_t                  kind;
  logic [jdisb_pkg::JOB_TAG_BITS-1:0] job_tag;
  logic [jdisb_pkg::WID_W-1:0]       worker_id;

  modport source (output valid, kind, job_tag, worker_id, input ready);
  modport sink (input valid, kind, job_tag, worker_id, output ready);
endinterface

interface jdisb_res_if;
  logic                              valid;
  logic                              ready;
  jdisb_pkg::action_t                action;
  logic [jdisb_pkg::WID_W-1:0]       assigned_worker;
  logic [jdisb_pkg::JOB_TAG_BITS-1:0] started_job;
  logic [jdisb_pkg::FILL_W-1:0]      backlog_level;

  modport source (output valid, action, assigned_worker, started_job, backlog_level,
                  input ready);
  modport sink (input valid, action, assigned_worker, started_job, backlog_level,
                output ready);
endinterface

interface jdisb_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [jdisb_pkg::CFG_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ rtl/job_dispatcher_idle_stack_backlog.sv @@
// Top level of the job dispatcher: joins controller and datapath to the channels.
// Depends on jdisb_pkg, jdisb_if, jdisb_ctrl and jdisb_dp.
//
// Channels: evt carries one event word (kind, job_tag, worker_id); res returns
// exactly one result word per event (action, assigned_worker, started_job,
// backlog_level); cfg writes the pool size, which reloads the idle stack and
// clears the active set, the backlog and the shutdown flag.
// A result passes from the capture registers through the execute-stage result
// registers into the output register. The controller handles one event at a
// time in its capture, execute and result-load steps; the backlog memory read
// takes place in the execute step.
// A new event is accepted while the previous result still sits unclaimed in the
// output register; the controller then holds in its wait step until res.ready.
// Reset (rst, synchronous): pool of 8 workers idle with the highest on top,
// empty backlog, shutdown flag clear, no result pending. cfg is always ready; the
// user must write it only while no event is in flight; the block does not check.
module job_dispatcher_idle_stack_backlog (
  input logic        clk,
  input logic        rst,
  jdisb_cfg_if.sink  cfg,
  jdisb_evt_if.sink  evt,
  jdisb_res_if.source res
);

  jdisb_pkg::dp_cmd_t cmd;

  assign cfg.ready = 1'b1;

  jdisb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .evt_valid (evt.valid),
    .evt_ready (evt.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .cmd       (cmd)
  );

  jdisb_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .kind            (evt.kind),
    .job_tag         (evt.job_tag),
    .worker_id       (evt.worker_id),
    .cfg_we          (cfg.valid),
    .cfg_data        (cfg.data),
    .action          (res.action),
    .assigned_worker (res.assigned_worker),
    .started_job     (res.started_job),
    .backlog_level   (res.backlog_level)
  );

endmodule

@@ rtl/jdisb_ctrl.sv @@
// Controller: sequences capture, execute and result load for one event word.
// Depends on jdisb_pkg and the assertion header.
`include "job_dispatcher_idle_stack_backlog_assert.svh"

module jdisb_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               evt_valid,
  output logic               evt_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output jdisb_pkg::dp_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT
  } state_t;

  state_t state;

  always_comb begin
    evt_ready    = (state == S_IDLE);
    cmd.capture  = evt_valid && (state == S_IDLE);
    cmd.exec     = (state == S_EXEC);
    cmd.load_out = (state == S_WAIT) && (!out_valid || out_ready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (evt_valid) state <= S_EXEC;
        S_EXEC: state <= S_WAIT;
        S_WAIT: if (!out_valid || out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `JDISB_ASSERT_NXT(a_capture_exec, cmd.capture, cmd.exec, "captured word not executed")
  `JDISB_ASSERT_NXT(a_exec_busy, cmd.exec, !evt_ready, "input open during result wait")
  `JDISB_ASSERT_NXT(a_load_valid, cmd.load_out, out_valid, "loaded result not presented")

endmodule

@@ rtl/jdisb_dp.sv @@
// Datapath: idle worker stack, active set, backlog ring memory and result registers.
// Depends on jdisb_pkg and the assertion header.
`include "job_dispatcher_idle_stack_backlog_assert.svh"

module jdisb_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  jdisb_pkg::dp_cmd_t                 cmd,
  input  jdisb_pkg::kind_t                   kind,
  input  logic [jdisb_pkg::JOB_TAG_BITS-1:0] job_tag,
  input  logic [jdisb_pkg::WID_W-1:0]        worker_id,
  input  logic                               cfg_we,
  input  logic [jdisb_pkg::CFG_W-1:0]        cfg_data,
  output jdisb_pkg::action_t                 action,
  output logic [jdisb_pkg::WID_W-1:0]        assigned_worker,
  output logic [jdisb_pkg::JOB_TAG_BITS-1:0] started_job,
  output logic [jdisb_pkg::FILL_W-1:0]       backlog_level
);

  function automatic logic [jdisb_pkg::CNT_W-1:0] clamp_count(
    input logic [jdisb_pkg::CFG_W-1:0] v
  );
    logic [jdisb_pkg::CNT_W-1:0] r;
    if (v == '0) begin
      r = jdisb_pkg::CNT_W'(1);
    end else if (int'(v) > jdisb_pkg::MAX_WORKERS) begin
      r = jdisb_pkg::CNT_W'(jdisb_pkg::MAX_WORKERS);
    end else begin
      r = jdisb_pkg::CNT_W'(v);
    end
    return r;
  endfunction

  function automatic logic [jdisb_pkg::PTR_W-1:0] ptr_inc(
    input logic [jdisb_pkg::PTR_W-1:0] p
  );
    logic [jdisb_pkg::PTR_W-1:0] r;
    if (p == jdisb_pkg::PTR_W'(jdisb_pkg::BACKLOG_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + 1'b1;
    end
    return r;
  endfunction

  jdisb_pkg::kind_t                   kind_q;
  logic [jdisb_pkg::JOB_TAG_BITS-1:0] tag_q;
  logic [jdisb_pkg::WID_W-1:0]        wid_q;

  logic [jdisb_pkg::CNT_W-1:0]        count;
  logic [jdisb_pkg::WID_W-1:0]        idle_stack [jdisb_pkg::MAX_WORKERS];
  logic [jdisb_pkg::CNT_W-1:0]        idle_top;
  logic [jdisb_pkg::MAX_WORKERS-1:0]  active;
  logic [jdisb_pkg::PTR_W-1:0]        head;
  logic [jdisb_pkg::PTR_W-1:0]        tail;
  logic [jdisb_pkg::FILL_W-1:0]       fill;
  logic                               stopping;

  logic [jdisb_pkg::JOB_TAG_BITS-1:0] backlog_mem [jdisb_pkg::BACKLOG_DEPTH];
  logic [jdisb_pkg::JOB_TAG_BITS-1:0] mem_rdata;

  jdisb_pkg::action_t                 res_action;
  logic [jdisb_pkg::WID_W-1:0]        res_worker;
  logic [jdisb_pkg::JOB_TAG_BITS-1:0] res_job;
  logic                               res_from_mem;
  logic [jdisb_pkg::FILL_W-1:0]       res_level;

  jdisb_pkg::action_t                 act;
  logic [jdisb_pkg::WID_W-1:0]        wkr;
  logic [jdisb_pkg::JOB_TAG_BITS-1:0] job;
  logic                               from_mem;
  logic                               pop;
  logic                               push;
  logic                               clr;
  logic                               enq;
  logic                               deq;
  logic                               shut;
  logic                               wid_ok;
  logic [jdisb_pkg::CNT_W-1:0]        top_m1;
  logic [jdisb_pkg::FILL_W-1:0]       fill_next;
  logic [jdisb_pkg::CNT_W-1:0]        init_count;

  assign init_count = rst ? clamp_count(jdisb_pkg::CFG_W'(jdisb_pkg::COUNT_RESET))
                          : clamp_count(cfg_data);
  assign top_m1 = idle_top - 1'b1;
  assign wid_ok = (jdisb_pkg::CNT_W'(wid_q) < count) && active[wid_q];

  always_comb begin
    act      = jdisb_pkg::ACT_ERROR;
    wkr      = '0;
    job      = '0;
    from_mem = 1'b0;
    pop      = 1'b0;
    push     = 1'b0;
    clr      = 1'b0;
    enq      = 1'b0;
    deq      = 1'b0;
    shut     = 1'b0;
    unique case (kind_q)
      jdisb_pkg::KIND_POST: begin
        job = tag_q;
        if (stopping) begin
          act = jdisb_pkg::ACT_DROP_SHUT;
        end else if (idle_top != '0) begin
          pop = 1'b1;
          wkr = idle_stack[top_m1[jdisb_pkg::WID_W-1:0]];
          act = jdisb_pkg::ACT_STARTED;
        end else if (fill == jdisb_pkg::FILL_W'(jdisb_pkg::BACKLOG_DEPTH)) begin
          act = jdisb_pkg::ACT_DROP_FULL;
        end else begin
          enq = 1'b1;
          act = jdisb_pkg::ACT_QUEUED;
        end
      end
      jdisb_pkg::KIND_FINISH: begin
        if (wid_ok) begin
          wkr = wid_q;
          if (fill != '0 && !stopping) begin
            deq      = 1'b1;
            from_mem = 1'b1;
            act      = jdisb_pkg::ACT_STARTED;
          end else begin
            clr  = 1'b1;
            push = (idle_top < jdisb_pkg::CNT_W'(jdisb_pkg::MAX_WORKERS));
            act  = jdisb_pkg::ACT_IDLE;
          end
        end
      end
      jdisb_pkg::KIND_SHUTDOWN: begin
        shut = 1'b1;
        act  = jdisb_pkg::ACT_SHUT_DONE;
      end
      default: ;
    endcase
    if (shut) begin
      fill_next = '0;
    end else if (enq) begin
      fill_next = fill + 1'b1;
    end else if (deq) begin
      fill_next = fill - 1'b1;
    end else begin
      fill_next = fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      count    <= init_count;
      idle_top <= init_count;
      active   <= '0;
      head     <= '0;
      tail     <= '0;
      fill     <= '0;
      stopping <= 1'b0;
      for (int i = 0; i < jdisb_pkg::MAX_WORKERS; i++) begin
        idle_stack[i] <= jdisb_pkg::WID_W'(i);
      end
    end else if (cmd.exec) begin
      if (pop) begin
        idle_top    <= top_m1;
        active[wkr] <= 1'b1;
      end
      if (push) begin
        idle_stack[idle_top[jdisb_pkg::WID_W-1:0]] <= wid_q;
        idle_top <= idle_top + 1'b1;
      end
      if (clr) active[wid_q] <= 1'b0;
      if (enq) tail <= ptr_inc(tail);
      if (deq) head <= ptr_inc(head);
      if (shut) begin
        head     <= '0;
        tail     <= '0;
        stopping <= 1'b1;
      end
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && enq) backlog_mem[tail] <= tag_q;
    if (cmd.exec && deq) mem_rdata <= backlog_mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_q <= kind;
      tag_q  <= job_tag;
      wid_q  <= worker_id;
    end
    if (cmd.exec) begin
      res_action   <= act;
      res_worker   <= wkr;
      res_job      <= job;
      res_from_mem <= from_mem;
      res_level    <= fill_next;
    end
    if (cmd.load_out) begin
      action          <= res_action;
      assigned_worker <= res_worker;
      started_job     <= res_from_mem ? mem_rdata : res_job;
      backlog_level   <= res_level;
    end
  end

  `JDISB_ASSERT_IMP(a_fill_bound, 1'b1, fill <= jdisb_pkg::FILL_W'(jdisb_pkg::BACKLOG_DEPTH), "backlog overfilled")
  `JDISB_ASSERT_IMP(a_top_bound, 1'b1, idle_top <= count, "idle stack above pool size")
  `JDISB_ASSERT_IMP(a_pool_sum, 1'b1, ($countones(active) + int'(idle_top)) == int'(count), "worker lost or duplicated")

endmodule
